### design/value_noise_2d_octaves_unit_macros.svh
// Assertion macros for the value noise unit.
// Used by the top level only; depends on nothing else.
`ifndef VALUE_NOISE_2D_OCTAVES_UNIT_MACROS_SVH
`define VALUE_NOISE_2D_OCTAVES_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VN2O_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VN2O_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/vn2o_pkg.sv
// Shared constants, types and the permutation table of the value noise unit.
// Used by vn2o_cell and value_noise_2d_octaves_unit; depends on nothing.
package vn2o_pkg;

   localparam int OCTAVE_COUNT  = 4;
   localparam int FRACTION_BITS = 16;

   localparam int COORD_W   = 32;
   localparam int FREQ_W    = 17;
   localparam int CELL_W    = 8;
   localparam int SEED_W    = CELL_W;
   localparam int NOISE_W   = 16;
   localparam int IN_TDATA_W  = 2 * COORD_W;
   localparam int OUT_TDATA_W = NOISE_W;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_INDEX_W = CSR_ADDR_W - 2;
   localparam logic [CSR_INDEX_W-1:0] REG_NOISE_SEED      = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FREQUENCY_SCALE = CSR_INDEX_W'(1);
   localparam logic [SEED_W-1:0] SEED_RESET = '0;
   localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(4096);

   localparam int PRODUCT_W = COORD_W + FREQ_W + 1;
   localparam int POINT_W   = FRACTION_BITS + CELL_W;
   localparam int POINT_LSB = COORD_W - FRACTION_BITS;
   localparam int VALUE_W   = FRACTION_BITS + CELL_W;
   localparam int ACC_W     = VALUE_W + OCTAVE_COUNT;

   localparam logic [FRACTION_BITS+1:0] SMOOTH_K = (FRACTION_BITS + 2)'(3) << FRACTION_BITS;

   localparam int WEIGHT_DIV  = (1 << OCTAVE_COUNT) - 1;
   localparam int NORM_SHIFT  = FRACTION_BITS + CELL_W - NOISE_W;
   localparam int NORM_W      = ACC_W - NORM_SHIFT;
   localparam int RECIP_SHIFT = NOISE_W + 2 * $clog2(WEIGHT_DIV + 1);
   localparam int RECIP_W     = RECIP_SHIFT - OCTAVE_COUNT + 2;
   localparam int QUOT_PROD_W = NORM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_MULT =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + WEIGHT_DIV - 1) / WEIGHT_DIV);
   localparam logic [ACC_W-1:0] SUM_LIMIT = ACC_W'(WEIGHT_DIV) << VALUE_W;

   typedef struct packed {
      logic                 valid;
      logic [POINT_W-1:0]   point_x;
      logic [POINT_W-1:0]   point_y;
      logic [ACC_W-1:0]     acc;
   } vn2o_link_type;

   localparam logic [7:0] PERM_ROM [256] = '{
      8'd208, 8'd34,  8'd231, 8'd213, 8'd32,  8'd248, 8'd233, 8'd56,
      8'd161, 8'd78,  8'd24,  8'd140, 8'd71,  8'd48,  8'd140, 8'd254,
      8'd245, 8'd255, 8'd247, 8'd247, 8'd40,  8'd185, 8'd248, 8'd251,
      8'd245, 8'd28,  8'd124, 8'd204, 8'd204, 8'd76,  8'd36,  8'd1,
      8'd107, 8'd28,  8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
      8'd167, 8'd204, 8'd9,   8'd92,  8'd217, 8'd54,  8'd239, 8'd174,
      8'd173, 8'd102, 8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108,
      8'd167, 8'd44,  8'd43,  8'd77,  8'd180, 8'd204, 8'd8,   8'd81,
      8'd70,  8'd223, 8'd11,  8'd38,  8'd24,  8'd254, 8'd210, 8'd210,
      8'd177, 8'd32,  8'd81,  8'd195, 8'd243, 8'd125, 8'd8,   8'd169,
      8'd112, 8'd32,  8'd97,  8'd53,  8'd195, 8'd13,  8'd203, 8'd9,
      8'd47,  8'd104, 8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203,
      8'd181, 8'd235, 8'd193, 8'd206, 8'd70,  8'd180, 8'd174, 8'd0,
      8'd167, 8'd181, 8'd41,  8'd164, 8'd30,  8'd116, 8'd127, 8'd198,
      8'd245, 8'd146, 8'd87,  8'd224, 8'd149, 8'd206, 8'd57,  8'd4,
      8'd192, 8'd210, 8'd65,  8'd210, 8'd129, 8'd240, 8'd178, 8'd105,
      8'd228, 8'd108, 8'd245, 8'd148, 8'd140, 8'd40,  8'd35,  8'd195,
      8'd38,  8'd58,  8'd65,  8'd207, 8'd215, 8'd253, 8'd65,  8'd85,
      8'd208, 8'd76,  8'd62,  8'd3,   8'd237, 8'd55,  8'd89,  8'd232,
      8'd50,  8'd217, 8'd64,  8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
      8'd90,  8'd17,  8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187,
      8'd234, 8'd177, 8'd73,  8'd174, 8'd193, 8'd100, 8'd192, 8'd143,
      8'd97,  8'd53,  8'd145, 8'd135, 8'd19,  8'd103, 8'd13,  8'd90,
      8'd135, 8'd151, 8'd199, 8'd91,  8'd239, 8'd247, 8'd33,  8'd39,
      8'd145, 8'd101, 8'd120, 8'd99,  8'd3,   8'd186, 8'd86,  8'd99,
      8'd41,  8'd237, 8'd203, 8'd111, 8'd79,  8'd220, 8'd135, 8'd158,
      8'd42,  8'd30,  8'd154, 8'd120, 8'd67,  8'd87,  8'd167, 8'd135,
      8'd176, 8'd183, 8'd191, 8'd253, 8'd115, 8'd184, 8'd21,  8'd233,
      8'd58,  8'd129, 8'd233, 8'd142, 8'd39,  8'd128, 8'd211, 8'd118,
      8'd137, 8'd139, 8'd255, 8'd114, 8'd20,  8'd218, 8'd113, 8'd154,
      8'd27,  8'd127, 8'd246, 8'd250, 8'd1,   8'd8,   8'd198, 8'd250,
      8'd209, 8'd92,  8'd222, 8'd173, 8'd21,  8'd88,  8'd102, 8'd219
   };

endpackage

### design/vn2o_cell.sv
// One octave cell of the value noise chain: hash, smoothstep, blend and accumulate.
// Depends on vn2o_pkg; instantiated in a row by value_noise_2d_octaves_unit.
module vn2o_cell import vn2o_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic [SEED_W-1:0]   seed,
   input  vn2o_link_type       link_in,
   output vn2o_link_type       link_out
);

   localparam int F = FRACTION_BITS;

   typedef struct packed {
      logic [POINT_W-1:0] point_x;
      logic [POINT_W-1:0] point_y;
      logic [ACC_W-1:0]   acc;
      logic [CELL_W-1:0]  row0;
      logic [CELL_W-1:0]  row1;
      logic [CELL_W-1:0]  cx;
      logic [F-1:0]       fx2;
      logic [F-1:0]       fy2;
      logic [F+1:0]       kx;
      logic [F+1:0]       ky;
   } stage1_type;

   typedef struct packed {
      logic [POINT_W-1:0] point_x;
      logic [POINT_W-1:0] point_y;
      logic [ACC_W-1:0]   acc;
      logic [CELL_W-1:0]  c00;
      logic [CELL_W-1:0]  c10;
      logic [CELL_W-1:0]  c01;
      logic [CELL_W-1:0]  c11;
      logic [F-1:0]       wx;
      logic [F-1:0]       wy;
   } stage2_type;

   typedef struct packed {
      logic [POINT_W-1:0] point_x;
      logic [POINT_W-1:0] point_y;
      logic [ACC_W-1:0]   acc;
      logic [VALUE_W-1:0] lo;
      logic [VALUE_W-1:0] hi;
      logic [F-1:0]       wy;
   } stage3_type;

   typedef struct packed {
      logic [POINT_W-1:0] point_x;
      logic [POINT_W-1:0] point_y;
      logic [ACC_W-1:0]   acc;
      logic [VALUE_W-1:0] value;
   } stage4_type;

   logic [3:0]  valid_ff, valid_in;
   stage1_type  s1_ff, s1_in;
   stage2_type  s2_ff, s2_in;
   stage3_type  s3_ff, s3_in;
   stage4_type  s4_ff, s4_in;

   logic [F-1:0]      fx, fy;
   logic [CELL_W-1:0] cy, row_y;
   logic [2*F-1:0]    sq_x, sq_y;
   logic [2*F+1:0]    sm_x, sm_y;
   logic [CELL_W-1:0] col0, col1;

   logic signed [CELL_W:0]          d_lo, d_hi;
   logic signed [F:0]               wx_s, wy_s;
   logic signed [F+CELL_W+1:0]      step_lo, step_hi, base_lo, base_hi, sum_lo, sum_hi;
   logic signed [VALUE_W:0]         d_v;
   logic signed [2*F+9:0]           v_prod, v_step, v_sum;

   always_comb begin
      fx    = link_in.point_x[F-1:0];
      fy    = link_in.point_y[F-1:0];
      cy    = link_in.point_y[POINT_W-1:F];
      row_y = cy + seed;
      sq_x  = (2*F)'(fx) * (2*F)'(fx);
      sq_y  = (2*F)'(fy) * (2*F)'(fy);

      s1_in.point_x = link_in.point_x;
      s1_in.point_y = link_in.point_y;
      s1_in.acc     = link_in.acc;
      s1_in.row0    = PERM_ROM[row_y];
      s1_in.row1    = PERM_ROM[row_y + CELL_W'(1)];
      s1_in.cx      = link_in.point_x[POINT_W-1:F];
      s1_in.fx2     = sq_x[2*F-1:F];
      s1_in.fy2     = sq_y[2*F-1:F];
      s1_in.kx      = SMOOTH_K - {1'b0, fx, 1'b0};
      s1_in.ky      = SMOOTH_K - {1'b0, fy, 1'b0};
   end

   always_comb begin
      col0 = s1_ff.cx;
      col1 = s1_ff.cx + CELL_W'(1);
      sm_x = (2*F+2)'(s1_ff.fx2) * (2*F+2)'(s1_ff.kx);
      sm_y = (2*F+2)'(s1_ff.fy2) * (2*F+2)'(s1_ff.ky);

      s2_in.point_x = s1_ff.point_x;
      s2_in.point_y = s1_ff.point_y;
      s2_in.acc     = s1_ff.acc;
      s2_in.c00     = PERM_ROM[s1_ff.row0 + col0];
      s2_in.c10     = PERM_ROM[s1_ff.row0 + col1];
      s2_in.c01     = PERM_ROM[s1_ff.row1 + col0];
      s2_in.c11     = PERM_ROM[s1_ff.row1 + col1];
      s2_in.wx      = sm_x[2*F-1:F];
      s2_in.wy      = sm_y[2*F-1:F];
   end

   always_comb begin
      d_lo    = $signed({1'b0, s2_ff.c10}) - $signed({1'b0, s2_ff.c00});
      d_hi    = $signed({1'b0, s2_ff.c11}) - $signed({1'b0, s2_ff.c01});
      wx_s    = $signed({1'b0, s2_ff.wx});
      step_lo = (F+CELL_W+2)'(d_lo) * (F+CELL_W+2)'(wx_s);
      step_hi = (F+CELL_W+2)'(d_hi) * (F+CELL_W+2)'(wx_s);
      base_lo = $signed({2'b00, s2_ff.c00, {F{1'b0}}});
      base_hi = $signed({2'b00, s2_ff.c01, {F{1'b0}}});
      sum_lo  = base_lo + step_lo;
      sum_hi  = base_hi + step_hi;

      s3_in.point_x = s2_ff.point_x;
      s3_in.point_y = s2_ff.point_y;
      s3_in.acc     = s2_ff.acc;
      s3_in.lo      = sum_lo[VALUE_W-1:0];
      s3_in.hi      = sum_hi[VALUE_W-1:0];
      s3_in.wy      = s2_ff.wy;
   end

   always_comb begin
      d_v    = $signed({1'b0, s3_ff.hi}) - $signed({1'b0, s3_ff.lo});
      wy_s   = $signed({1'b0, s3_ff.wy});
      v_prod = (2*F+10)'(d_v) * (2*F+10)'(wy_s);
      v_step = v_prod >>> F;
      v_sum  = $signed({{(F+2){1'b0}}, s3_ff.lo}) + v_step;

      s4_in.point_x = s3_ff.point_x;
      s4_in.point_y = s3_ff.point_y;
      s4_in.acc     = s3_ff.acc;
      s4_in.value   = v_sum[VALUE_W-1:0];
   end

   assign valid_in = {valid_ff[2:0], link_in.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   // The next octave sees the point at twice the scale and the sum at twice the weight.
   always_comb begin
      link_out.valid   = valid_ff[3];
      link_out.point_x = {s4_ff.point_x[POINT_W-2:0], 1'b0};
      link_out.point_y = {s4_ff.point_y[POINT_W-2:0], 1'b0};
      link_out.acc     = {s4_ff.acc[ACC_W-2:0], 1'b0} + ACC_W'(s4_ff.value);
   end

endmodule

### design/value_noise_2d_octaves_unit.sv
// Top level of the four-octave 2D value noise unit: stream ports, APB registers,
// input scaling, the row of octave cells and the output normalization.
// Depends on vn2o_pkg, vn2o_cell and value_noise_2d_octaves_unit_macros.svh.
// The stages are an input register, four stages per cell, a sum register and an output register.
// Throughput is one transfer per cycle; the whole pipeline holds while a result waits.
// Reset clears the stage valid bits and loads noise_seed = 0, frequency_scale = 4096.
`include "value_noise_2d_octaves_unit_macros.svh"

module value_noise_2d_octaves_unit import vn2o_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [IN_TDATA_W-1:0]  req_tdata,   // coord_x [31:0], coord_y [63:32]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [OUT_TDATA_W-1:0] rsp_tdata,   // noise_value [15:0]
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [SEED_W-1:0]      seed_ff, seed_in;
   logic [FREQ_W-1:0]      freq_ff, freq_in;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      seed_in = seed_ff;
      freq_in = freq_ff;
      if (csr_write) begin
         case (csr_index)
            REG_NOISE_SEED: begin
               seed_in = csr_pwdata[SEED_W-1:0];
            end
            REG_FREQUENCY_SCALE: begin
               freq_in = csr_pwdata[FREQ_W-1:0];
            end
            default: begin
               seed_in = seed_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_NOISE_SEED:      csr_prdata = CSR_DATA_W'(seed_ff);
         REG_FREQUENCY_SCALE: csr_prdata = CSR_DATA_W'(freq_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
         freq_ff <= FREQ_RESET;
      end else begin
         seed_ff <= seed_in;
         freq_ff <= freq_in;
      end
   end

   logic                        pipe_enable;
   logic                        in_valid_ff;
   logic signed [COORD_W-1:0]   coord_x, coord_y;
   logic signed [FREQ_W:0]      freq_s;
   logic signed [PRODUCT_W-1:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;

   assign pipe_enable = !rsp_tvalid || rsp_tready;
   assign req_tready  = pipe_enable;

   assign coord_x   = $signed(req_tdata[COORD_W-1:0]);
   assign coord_y   = $signed(req_tdata[2*COORD_W-1:COORD_W]);
   assign freq_s    = $signed({1'b0, freq_ff});
   assign prod_x_in = PRODUCT_W'(coord_x) * PRODUCT_W'(freq_s);
   assign prod_y_in = PRODUCT_W'(coord_y) * PRODUCT_W'(freq_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
      end
   end

   vn2o_link_type link [OCTAVE_COUNT+1];

   assign link[0] = {in_valid_ff,
                     prod_x_ff[POINT_LSB+POINT_W-1:POINT_LSB],
                     prod_y_ff[POINT_LSB+POINT_W-1:POINT_LSB],
                     ACC_W'(0)};

   for (genvar i = 0; i < OCTAVE_COUNT; i++) begin : g_octave
      vn2o_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (pipe_enable),
         .seed     (seed_ff),
         .link_in  (link[i]),
         .link_out (link[i+1])
      );
   end

   logic                   sum_valid_ff;
   logic [ACC_W-1:0]       sum_ff;
   logic [NORM_W-1:0]      norm_n;
   logic [QUOT_PROD_W-1:0] quot_prod;
   logic                   rsp_valid_ff;
   logic [NOISE_W-1:0]     rsp_data_ff, rsp_data_in;

   assign norm_n      = sum_ff[ACC_W-1:NORM_SHIFT];
   assign quot_prod   = QUOT_PROD_W'(norm_n) * QUOT_PROD_W'(RECIP_MULT);
   assign rsp_data_in = quot_prod[RECIP_SHIFT+NOISE_W-1:RECIP_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_enable) begin
         sum_valid_ff <= link[OCTAVE_COUNT].valid;
         rsp_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_enable) begin
         sum_ff      <= link[OCTAVE_COUNT].acc;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `VN2O_ASSERT_IMPLY(a_sum_in_range, clock, reset, sum_valid_ff,
      sum_ff < SUM_LIMIT, "octave sum out of range")
   `VN2O_ASSERT_IMPLY(a_quotient_fits, clock, reset, sum_valid_ff,
      quot_prod[QUOT_PROD_W-1:RECIP_SHIFT+NOISE_W] == '0, "normalized value overflows")
   `VN2O_ASSERT_NEXT(a_stall_holds_sum, clock, reset, !pipe_enable && sum_valid_ff,
      sum_valid_ff && $stable(sum_ff), "sum stage moved during a stall")

endmodule
